// File: src/dzv_pkg.sv
// ----------------------------------------------------------------------------
// dzv_pkg
// Shared types and constants for the delta / zigzag / varint encoder.
// ----------------------------------------------------------------------------
package dzv_pkg;

    // Default width of the number path
    localparam int VALUE_WIDTH_DEF = 64;

    // Field widths fixed by the interface
    localparam int IN_VALUE_BITS = 64;
    localparam int CODE_BITS     = 8;

    // Varint group layout
    localparam int          GROUP_BITS = 7;
    localparam logic [6:0]  GROUP_MASK = 7'h7F;
    localparam logic        MORE_FLAG  = 1'b1;

    // Reset value of delta_mode
    localparam logic DELTA_MODE_RST = 1'b1;

    // Depth of the queue between the front and the back end
    localparam int QUEUE_DEPTH = 2;

    // Input beat: one number
    typedef struct packed {
        logic signed [IN_VALUE_BITS-1:0] value;
        logic                            list_start;
    } in_beat_t;

    // Output beat: one code byte
    typedef struct packed {
        logic [CODE_BITS-1:0] code_byte;
        logic                 last_byte;
    } out_beat_t;

    // Back end states
    typedef enum logic {
        BK_IDLE,
        BK_EMIT
    } bk_state_t;

endpackage

// File: src/dzv_front.sv
// ----------------------------------------------------------------------------
// dzv_front
// Accepts numbers, forms the delta against the previous one (in delta mode, not
// at list start), applies the zigzag map and pushes the mapped word to the queue.
// ----------------------------------------------------------------------------
module dzv_front #(
    parameter int VALUE_WIDTH = dzv_pkg::VALUE_WIDTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic                   cfg_wdata,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  dzv_pkg::in_beat_t      in_data,
    output logic                   push_valid,
    input  logic                   push_ready,
    output logic [VALUE_WIDTH-1:0] push_word
);
    import dzv_pkg::*;

    logic                   delta_mode_reg;
    logic [VALUE_WIDTH-1:0] prev_reg;
    logic [VALUE_WIDTH-1:0] prev_next;
    logic [VALUE_WIDTH-1:0] v;
    logic [VALUE_WIDTH-1:0] d;
    logic                   accept;

    // Handshake: the front takes a beat whenever the queue has room
    assign in_ready   = push_ready;
    assign push_valid = in_valid;
    assign accept     = in_valid && push_ready;

    // Delta and zigzag map
    assign v = in_data.value[VALUE_WIDTH-1:0];

    always_comb
    begin
        if (delta_mode_reg && !in_data.list_start)
        begin
            d = v - prev_reg;
        end
        else
        begin
            d = v;
        end
        push_word = {d[VALUE_WIDTH-2:0], 1'b0} ^ {VALUE_WIDTH{d[VALUE_WIDTH-1]}};
        prev_next = accept ? v : prev_reg;
    end

    // Mode register and previous number
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delta_mode_reg <= DELTA_MODE_RST;
            prev_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                delta_mode_reg <= cfg_wdata;
            end
            prev_reg <= prev_next;
        end
    end

endmodule

// File: src/dzv_queue.sv
// ----------------------------------------------------------------------------
// dzv_queue
// Short FIFO of mapped words between the front and the back end.
// ----------------------------------------------------------------------------
module dzv_queue #(
    parameter int VALUE_WIDTH = dzv_pkg::VALUE_WIDTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push_valid,
    output logic                   push_ready,
    input  logic [VALUE_WIDTH-1:0] push_word,
    output logic                   pop_valid,
    input  logic                   pop_ready,
    output logic [VALUE_WIDTH-1:0] pop_word
);
    import dzv_pkg::*;

    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    logic [VALUE_WIDTH-1:0] mem [QUEUE_DEPTH];
    logic [PTR_BITS-1:0]    wr_ptr_reg;
    logic [PTR_BITS-1:0]    wr_ptr_next;
    logic [PTR_BITS-1:0]    rd_ptr_reg;
    logic [PTR_BITS-1:0]    rd_ptr_next;
    logic [CNT_BITS-1:0]    count_reg;
    logic [CNT_BITS-1:0]    count_next;
    logic                   push;
    logic                   pop;

    assign push_ready = (count_reg != CNT_BITS'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_word   = mem[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + PTR_BITS'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + PTR_BITS'(1);
        end
        count_next = count_reg + CNT_BITS'(push) - CNT_BITS'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_word;
        end
    end

endmodule

// File: src/dzv_back.sv
// ----------------------------------------------------------------------------
// dzv_back
// Takes mapped words from the queue and shifts them out as 7-bit groups,
// one code byte per cycle while out_ready is high, through an output register.
// ----------------------------------------------------------------------------
module dzv_back #(
    parameter int VALUE_WIDTH = dzv_pkg::VALUE_WIDTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   pop_valid,
    output logic                   pop_ready,
    input  logic [VALUE_WIDTH-1:0] pop_word,
    output logic                   out_valid,
    input  logic                   out_ready,
    output dzv_pkg::out_beat_t     out_data
);
    import dzv_pkg::*;

    bk_state_t              state_reg;
    bk_state_t              state_next;
    logic [VALUE_WIDTH-1:0] cur_reg;
    logic [VALUE_WIDTH-1:0] cur_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    out_beat_t              out_data_reg;
    out_beat_t              out_data_next;
    logic                   slot_free;
    logic                   final_group;
    logic                   emit;

    assign out_valid   = out_valid_reg;
    assign out_data    = out_data_reg;
    assign slot_free   = !out_valid_reg || out_ready;
    assign final_group = (cur_reg[VALUE_WIDTH-1:GROUP_BITS] == '0);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (pop_valid)
                begin
                    state_next = BK_EMIT;
                end
            end
            BK_EMIT:
            begin
                if (slot_free && final_group && !pop_valid)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Datapath and handshake outputs
    always_comb
    begin
        pop_ready      = 1'b0;
        emit           = 1'b0;
        cur_next       = cur_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                pop_ready = 1'b1;
            end
            BK_EMIT:
            begin
                emit = slot_free;
                // the last group of a word frees the shifter for the next one
                pop_ready = slot_free && final_group;
            end
            default:
            begin
                pop_ready = 1'b0;
            end
        endcase

        if (emit)
        begin
            out_valid_next          = 1'b1;
            out_data_next.code_byte = {(final_group ? !MORE_FLAG : MORE_FLAG),
                                       cur_reg[GROUP_BITS-1:0] & GROUP_MASK};
            out_data_next.last_byte = final_group;
            cur_next                = cur_reg >> GROUP_BITS;
        end
        if (pop_ready && pop_valid)
        begin
            cur_next = pop_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        out_data_reg <= out_data_next;
    end

endmodule

// File: src/delta_zigzag_varint_encoder.sv
// A number goes through the word queue and the group shifter into the output register.
// Throughput: one code byte per cycle while out_ready is high, set by the 7-bit group
// shifter in the back end; a number gives 1 to ceil(VALUE_WIDTH/7) bytes (10 at 64 bits).
// The two-entry word queue lets the front take numbers while the back end shifts.
// Reset (rst_n, asynchronous, active low): delta mode on, previous number zero,
// queue and output register empty.
// ----------------------------------------------------------------------------
// delta_zigzag_varint_encoder
// Delta, zigzag and LEB128-style varint encoder: front end for the delta and
// zigzag map, a short word queue, and a back end that emits code bytes.
// ----------------------------------------------------------------------------
module delta_zigzag_varint_encoder #(
    parameter int VALUE_WIDTH = dzv_pkg::VALUE_WIDTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_wdata,
    input  logic               in_valid,
    output logic               in_ready,
    input  dzv_pkg::in_beat_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output dzv_pkg::out_beat_t out_data
);
    import dzv_pkg::*;

    logic                   push_valid;
    logic                   push_ready;
    logic [VALUE_WIDTH-1:0] push_word;
    logic                   pop_valid;
    logic                   pop_ready;
    logic [VALUE_WIDTH-1:0] pop_word;

    // Delta and zigzag map
    dzv_front #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_word  (push_word)
    );

    // Word queue
    dzv_queue #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_word  (push_word),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_word   (pop_word)
    );

    // Group shifter and output register
    dzv_back #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_word  (pop_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
